// ===== rtl/matrix4x4_multiply_assert.svh =====
// assertion macros for the matrix multiplier checker
`ifndef MATRIX4X4_MULTIPLY_ASSERT_SVH
`define MATRIX4X4_MULTIPLY_ASSERT_SVH

// same-cycle implication, reset masked
`define MX4_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define MX4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication a fixed number of cycles later, reset masked
`define MX4_ASSERT_LATER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// ===== rtl/mx4_pkg.sv =====
// shared constants and types for the matrix multiplier
package mx4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int DIM_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ELEMS     = DIM * DIM;
  localparam int IDX_W     = $clog2(ELEMS);
  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + DIM_W;
  localparam int FUNC_W    = 2;
  localparam int RIDX_W    = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A   = 2'd0,
    FUNC_LOAD_B   = 2'd1,
    FUNC_MULTIPLY = 2'd2
  } func_t;

  // tag that travels with each product through the pipe
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             done;
    logic             last;
    logic [IDX_W-1:0] res_idx;
  } tag_t;

endpackage

// ===== rtl/mx4_ram.sv =====
// generic single-write, single-read ram with registered read data
module mx4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/matrix4x4_multiply.sv =====
// top level of the fixed-point 4x4 matrix multiplier
//
// A beat with start high while busy is low is taken. func load A / load B writes
// one signed Q16.16 element into the left or right store in that single cycle and
// never raises busy; an index beyond the store and the unused func code are dropped.
// A multiply beat raises busy and walks all 64 products, one per clock, through
// the single 32x32 multiplier fed by one read port on each store; busy stays high
// and drops in the cycle that shows the last result. Results come out in flat
// index order, one after each full inner sum of DIM = 4 products, each on the out_
// ports for exactly one cycle with out_valid high; the receiver cannot stall, so it
// must take every beat as it appears. Each result is the full-width sum of four
// products, shifted right by 16 toward minus infinity and saturated to 32 bits.
// Both stores read as zero after reset, tracked by one valid bit per entry.
module matrix4x4_multiply (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [mx4_pkg::FUNC_W-1:0]         in_func,
  input  logic [3:0]                         in_element_index,
  input  logic signed [mx4_pkg::ELEM_W-1:0]  in_element_value,
  output logic                               out_valid,
  output logic [mx4_pkg::RIDX_W-1:0]         out_result_index,
  output logic signed [mx4_pkg::ELEM_W-1:0]  out_result_value,
  output logic                               out_last_result
);

  localparam int ELEMS  = mx4_pkg::ELEMS;
  localparam int IDX_W  = mx4_pkg::IDX_W;
  localparam int DIM_W  = mx4_pkg::DIM_W;
  localparam int ELEM_W = mx4_pkg::ELEM_W;
  localparam int PROD_W = mx4_pkg::PROD_W;
  localparam int ACC_W  = mx4_pkg::ACC_W;
  localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(mx4_pkg::DIM - 1);

  // ---------------------------------------------------------------------------
  // input beat decode
  // ---------------------------------------------------------------------------
  logic             busy_r, busy_nxt;
  logic             take;
  logic             in_range;
  logic             we_a;
  logic             we_b;
  logic             go_mul;
  logic [IDX_W-1:0] waddr;

  assign take     = start && !busy_r;
  // widen both sides so the range check holds for any store size
  assign in_range = (32'(in_element_index) < 32'(ELEMS));
  assign waddr    = IDX_W'(in_element_index);
  assign we_a     = take && (in_func == mx4_pkg::FUNC_LOAD_A) && in_range;
  assign we_b     = take && (in_func == mx4_pkg::FUNC_LOAD_B) && in_range;
  assign go_mul   = take && (in_func == mx4_pkg::FUNC_MULTIPLY);

  // ---------------------------------------------------------------------------
  // per-entry valid bits: an entry never written since reset reads as zero
  // ---------------------------------------------------------------------------
  logic [ELEMS-1:0] vld_a_r, vld_a_nxt;
  logic [ELEMS-1:0] vld_b_r, vld_b_nxt;

  always_comb begin
    vld_a_nxt = vld_a_r;
    vld_b_nxt = vld_b_r;
    if (we_a) begin
      vld_a_nxt[waddr] = 1'b1;
    end
    if (we_b) begin
      vld_b_nxt[waddr] = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // issue sequencer: row r, column e, inner term c; c runs fastest
  // ---------------------------------------------------------------------------
  logic             issue_r, issue_nxt;
  logic [DIM_W-1:0] r_r, r_nxt;
  logic [DIM_W-1:0] e_r, e_nxt;
  logic [DIM_W-1:0] c_r, c_nxt;
  logic             last_issue;

  assign last_issue = (r_r == DIM_LAST) && (e_r == DIM_LAST) && (c_r == DIM_LAST);

  always_comb begin
    issue_nxt = issue_r;
    r_nxt     = r_r;
    e_nxt     = e_r;
    c_nxt     = c_r;
    if (go_mul) begin
      issue_nxt = 1'b1;
      r_nxt     = '0;
      e_nxt     = '0;
      c_nxt     = '0;
    end else if (issue_r) begin
      if (last_issue) begin
        issue_nxt = 1'b0;
      end
      if (c_r == DIM_LAST) begin
        c_nxt = '0;
        if (e_r == DIM_LAST) begin
          e_nxt = '0;
          r_nxt = r_r + 1'b1;
        end else begin
          e_nxt = e_r + 1'b1;
        end
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
  end

  // store addresses: A[r][c] and B[c][e]
  logic [IDX_W-1:0] raddr_a;
  logic [IDX_W-1:0] raddr_b;

  assign raddr_a = IDX_W'(r_r * mx4_pkg::DIM + c_r);
  assign raddr_b = IDX_W'(c_r * mx4_pkg::DIM + e_r);

  mx4_pkg::tag_t tag0;

  always_comb begin
    tag0.vld     = issue_r;
    tag0.first   = (c_r == '0);
    tag0.done    = (c_r == DIM_LAST);
    tag0.last    = last_issue;
    tag0.res_idx = IDX_W'(r_r * mx4_pkg::DIM + e_r);
  end

  // ---------------------------------------------------------------------------
  // element stores
  // ---------------------------------------------------------------------------
  logic [ELEM_W-1:0] rdata_a;
  logic [ELEM_W-1:0] rdata_b;

  mx4_ram #(.WIDTH(ELEM_W), .DEPTH(ELEMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mx4_ram #(.WIDTH(ELEM_W), .DEPTH(ELEMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // ---------------------------------------------------------------------------
  // stage 1: read data back, mask unwritten entries, multiply
  // stores do not change while busy, so no forwarding is needed
  // ---------------------------------------------------------------------------
  mx4_pkg::tag_t            tag1_r;
  logic                     ok_a_r;
  logic                     ok_b_r;
  logic signed [ELEM_W-1:0] op_a;
  logic signed [ELEM_W-1:0] op_b;

  assign op_a = ok_a_r ? signed'(rdata_a) : '0;
  assign op_b = ok_b_r ? signed'(rdata_b) : '0;

  // ---------------------------------------------------------------------------
  // stage 2: product register; stage 3: running sum over the inner term
  // ---------------------------------------------------------------------------
  mx4_pkg::tag_t            tag2_r;
  logic signed [PROD_W-1:0] prod_r;
  mx4_pkg::tag_t            tag3_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  assign acc_nxt = (tag2_r.first ? '0 : acc_r) + ACC_W'(prod_r);

  // ---------------------------------------------------------------------------
  // stage 4: shift right, saturate, drive the result beat
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-ELEM_W:0]    upper;
  logic signed [ELEM_W-1:0] sat_val;
  logic                     emit;

  assign shifted = acc_r >>> mx4_pkg::FRAC_BITS;
  // bits at and above the 32-bit sign bit must all agree for the value to fit
  assign upper   = shifted[ACC_W-1:ELEM_W-1];
  assign emit    = tag3_r.vld && tag3_r.done;

  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat_val = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  // busy drops as the final result is loaded into the output register
  always_comb begin
    busy_nxt = busy_r;
    if (go_mul) begin
      busy_nxt = 1'b1;
    end else if (emit && tag3_r.last) begin
      busy_nxt = 1'b0;
    end
  end

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [ELEM_W-1:0] out_val_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= '0;
      vld_b_r     <= '0;
      busy_r      <= 1'b0;
      issue_r     <= 1'b0;
      r_r         <= '0;
      e_r         <= '0;
      c_r         <= '0;
      tag1_r      <= '0;
      tag2_r      <= '0;
      tag3_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      vld_a_r     <= vld_a_nxt;
      vld_b_r     <= vld_b_nxt;
      busy_r      <= busy_nxt;
      issue_r     <= issue_nxt;
      r_r         <= r_nxt;
      e_r         <= e_nxt;
      c_r         <= c_nxt;
      tag1_r      <= tag0;
      tag2_r      <= tag1_r;
      tag3_r      <= tag2_r;
      out_valid_r <= emit;
      out_last_r  <= emit && tag3_r.last;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    ok_a_r <= vld_a_r[raddr_a];
    ok_b_r <= vld_b_r[raddr_b];
    prod_r <= op_a * op_b;
    if (tag2_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (emit) begin
      out_idx_r <= tag3_r.res_idx;
      out_val_r <= sat_val;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_result_index = mx4_pkg::RIDX_W'(out_idx_r);
  assign out_result_value = out_val_r;
  assign out_last_result  = out_last_r;

endmodule

// ===== rtl/mx4_chk.sv =====
// port-level checker for the matrix multiplier, bound to the top level
`include "matrix4x4_multiply_assert.svh"

module mx4_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [mx4_pkg::FUNC_W-1:0]         in_func,
  input logic [3:0]                         in_element_index,
  input logic signed [mx4_pkg::ELEM_W-1:0]  in_element_value,
  input logic                               out_valid,
  input logic [mx4_pkg::RIDX_W-1:0]         out_result_index,
  input logic signed [mx4_pkg::ELEM_W-1:0]  out_result_value,
  input logic                               out_last_result
);

  localparam logic [mx4_pkg::RIDX_W-1:0] LAST_IDX = mx4_pkg::RIDX_W'(mx4_pkg::ELEMS - 1);
  localparam int GAP = mx4_pkg::DIM;

  // index the next result beat should carry
  logic [mx4_pkg::RIDX_W-1:0] idx_inc;

  assign idx_inc = out_result_index + 1'b1;

  // a multiply beat always raises busy
  `MX4_ASSERT_NEXT(a_mul_busy, start && !busy && in_func == mx4_pkg::FUNC_MULTIPLY, busy, "multiply beat did not raise busy")

  // the final beat carries the top index and ends the job
  `MX4_ASSERT_NOW(a_last_idx, out_valid && out_last_result, out_result_index == LAST_IDX && !busy, "bad final result beat")

  // results only come out during a job, apart from the final one
  `MX4_ASSERT_NOW(a_out_busy, out_valid && !out_last_result, busy, "result beat outside a job")

  // the next result follows one inner sum later with the next index
  `MX4_ASSERT_LATER(a_cadence, out_valid && !out_last_result, GAP, out_valid && out_result_index == $past(idx_inc, GAP), "result cadence or order broken")

endmodule

bind matrix4x4_multiply mx4_chk u_mx4_chk (.*);

// ===== tb/matrix4x4_multiply_tb.sv =====
// self-checking testbench for the fixed-point 4x4 matrix multiplier
`timescale 1ns / 1ps

module matrix4x4_multiply_tb;
  import mx4_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 5;
  localparam int NUM_DIR = 20;
  localparam int RAND_ITEMS = 230;
  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  // the func code that the block drops
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // one product element as it leaves the block
  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        last;
  } product_t;

  // one row of the directed table; first_val is the typed-in result 0 when typed is set
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [3:0]        idx;
    logic [31:0]       val;
    logic              typed;
    logic [31:0]       first_val;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [FUNC_W-1:0]        in_func;
  logic [3:0]               in_element_index;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     out_valid;
  logic [RIDX_W-1:0]        out_result_index;
  logic signed [ELEM_W-1:0] out_result_value;
  logic                     out_last_result;

  // predictor copy of the two element stores
  logic signed [31:0] left_store [ELEMS];
  logic signed [31:0] right_store [ELEMS];

  // products still owed by the block, oldest first
  product_t product_q [$];
  stim_row_t dir_tab [NUM_DIR];

  int errors = 0;
  int loads_sent = 0;
  int mults_sent = 0;
  int dropped_sent = 0;
  int products_checked = 0;
  int saturated_seen = 0;
  int cycle_cnt = 0;

  matrix4x4_multiply dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_result_index (out_result_index),
    .out_result_value (out_result_value),
    .out_last_result  (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog, sized far above the slowest legal run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d products outstanding", cycle_cnt,
               product_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // result checker: every strobe must match the oldest owed product
  always @(posedge clk) begin
    product_t want;
    if (rst_n && out_valid) begin
      if (product_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected product beat index %0d value %h last %b", $time,
                 out_result_index, out_result_value, out_last_result);
      end else begin
        want = product_q.pop_front();
        products_checked++;
        if (out_result_value == 32'sh7FFF_FFFF || out_result_value == 32'sh8000_0000)
          saturated_seen++;
        if (out_result_index !== want.idx) begin
          errors++;
          $display("%0t: result_index expected %0d actual %0d", $time, want.idx,
                   out_result_index);
        end
        if (out_result_value !== want.val) begin
          errors++;
          $display("%0t: result_value at index %0d expected %h actual %h", $time,
                   want.idx, want.val, out_result_value);
        end
        if (out_last_result !== want.last) begin
          errors++;
          $display("%0t: last_result at index %0d expected %b actual %b", $time,
                   want.idx, want.last, out_last_result);
        end
      end
    end
  end

  // drive one beat after gap idle cycles, then update the predictor once it is taken
  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [3:0] idx,
                           input logic [31:0] val, input int gap, input logic typed,
                           input logic [31:0] first_val);
    logic signed [67:0] acc;
    logic signed [67:0] shifted;
    product_t p;
    int base;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start            <= 1'b1;
    in_func          <= f;
    in_element_index <= idx;
    in_element_value <= val;
    // busy sampled at the edge is its value before the edge
    do @(posedge clk); while (busy);
    case (f)
      FUNC_LOAD_A: begin
        if (idx < ELEMS) left_store[idx] = val;
        loads_sent++;
      end
      FUNC_LOAD_B: begin
        if (idx < ELEMS) right_store[idx] = val;
        loads_sent++;
      end
      FUNC_MULTIPLY: begin
        base = product_q.size();
        for (int r = 0; r < DIM; r++) begin
          for (int e = 0; e < DIM; e++) begin
            // exact sum of four 64-bit products, then floor shift and clamp
            acc = '0;
            for (int c = 0; c < DIM; c++)
              acc = acc + left_store[r * DIM + c] * right_store[c * DIM + e];
            shifted = acc >>> FRAC_BITS;
            if (shifted[67:31] != '0 && shifted[67:31] != '1)
              p.val = shifted[67] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
              p.val = shifted[31:0];
            p.idx  = 4'(r * DIM + e);
            p.last = (r * DIM + e == ELEMS - 1);
            product_q.push_back(p);
          end
        end
        if (typed) product_q[base].val = first_val;
        mults_sent++;
      end
      default: dropped_sent++;
    endcase
  endtask

  // element values: small q16 numbers, raw words, extremes, or large magnitudes
  function automatic logic [31:0] draw_element(input int flavor);
    case (flavor)
      0: draw_element = 32'($urandom_range(0, 20'hF_FFFF)) - 32'h0008_0000;
      1: draw_element = $urandom();
      2: begin
        case ($urandom_range(0, 6))
          0: draw_element = 32'h8000_0000;
          1: draw_element = 32'h7FFF_FFFF;
          2: draw_element = 32'h0000_0000;
          3: draw_element = 32'h0000_0001;
          4: draw_element = 32'hFFFF_FFFF;
          5: draw_element = 32'h0001_0000;
          default: draw_element = 32'hFFFF_0000;
        endcase
      end
      default: draw_element = {16'($urandom_range(0, 16'h7FFF)) ^
                               ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000),
                               16'($urandom())};
    endcase
  endfunction

  initial begin
    int job_flavor;
    int nloads;
    int sent;
    int gap;
    logic burst;
    logic [FUNC_W-1:0] f;

    rst_n            = 1'b0;
    start            = 1'b0;
    in_func          = '0;
    in_element_index = '0;
    in_element_value = '0;
    for (int i = 0; i < ELEMS; i++) begin
      left_store[i]  = '0;
      right_store[i] = '0;
    end

    // directed rows: reset contents, dropped code, saturation both ways,
    // unit product, floor of a tiny negative, last index, ignored multiply fields
    dir_tab[0]  = '{FUNC_MULTIPLY, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000};
    dir_tab[1]  = '{FUNC_UNUSED,   4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0};
    dir_tab[2]  = '{FUNC_LOAD_A,   4'd0,  32'h8000_0000, 1'b0, 32'h0};
    dir_tab[3]  = '{FUNC_LOAD_B,   4'd0,  32'h8000_0000, 1'b0, 32'h0};
    dir_tab[4]  = '{FUNC_MULTIPLY, 4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF};
    dir_tab[5]  = '{FUNC_LOAD_B,   4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0};
    dir_tab[6]  = '{FUNC_MULTIPLY, 4'd0,  32'h0000_0000, 1'b1, 32'h8000_0000};
    dir_tab[7]  = '{FUNC_LOAD_A,   4'd0,  32'h0001_0000, 1'b0, 32'h0};
    dir_tab[8]  = '{FUNC_LOAD_B,   4'd0,  32'h0001_0000, 1'b0, 32'h0};
    dir_tab[9]  = '{FUNC_MULTIPLY, 4'd0,  32'h0000_0000, 1'b1, 32'h0001_0000};
    dir_tab[10] = '{FUNC_LOAD_A,   4'd0,  32'hFFFF_FFFF, 1'b0, 32'h0};
    dir_tab[11] = '{FUNC_LOAD_B,   4'd0,  32'h0000_0001, 1'b0, 32'h0};
    dir_tab[12] = '{FUNC_MULTIPLY, 4'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF};
    dir_tab[13] = '{FUNC_LOAD_A,   4'd15, 32'h7FFF_FFFF, 1'b0, 32'h0};
    dir_tab[14] = '{FUNC_LOAD_B,   4'd15, 32'h7FFF_FFFF, 1'b0, 32'h0};
    dir_tab[15] = '{FUNC_MULTIPLY, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0};
    dir_tab[16] = '{FUNC_UNUSED,   4'd15, 32'h5555_5555, 1'b0, 32'h0};
    dir_tab[17] = '{FUNC_LOAD_A,   4'd5,  32'hAAAA_AAAA, 1'b0, 32'h0};
    dir_tab[18] = '{FUNC_LOAD_B,   4'd6,  32'h5555_5555, 1'b0, 32'h0};
    dir_tab[19] = '{FUNC_MULTIPLY, 4'd10, 32'hAAAA_AAAA, 1'b0, 32'h0};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++)
      send_beat(dir_tab[i].func, dir_tab[i].idx, dir_tab[i].val, $urandom_range(0, 4),
                dir_tab[i].typed, dir_tab[i].first_val);

    // hold the sender off until the block has drained completely
    @(negedge clk);
    start <= 1'b0;
    wait (product_q.size() == 0);

    // random jobs: a run of loads with random content, then a multiply,
    // with dropped codes mixed in as noise
    sent = 0;
    while (sent < RAND_ITEMS) begin
      job_flavor = $urandom_range(0, 3);
      burst = ($urandom_range(0, 3) == 0);
      nloads = $urandom_range(0, 10);
      for (int k = 0; k < nloads; k++) begin
        gap = burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 19) == 0)
          f = FUNC_UNUSED;
        else
          f = $urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A;
        send_beat(f, 4'($urandom()),
                  draw_element(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                           : job_flavor),
                  gap, 1'b0, 32'h0);
        if (f != FUNC_UNUSED) sent++;
      end
      gap = burst ? 0 : $urandom_range(0, 4);
      send_beat(FUNC_MULTIPLY, 4'($urandom()), $urandom(), gap, 1'b0, 32'h0);
      sent++;
      if ($urandom_range(0, 7) == 0) begin
        @(negedge clk);
        start <= 1'b0;
        wait (product_q.size() == 0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (product_q.size() == 0);
    // a few more cycles so that any stray beat is caught
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d multiplies and %0d dropped beats", loads_sent,
             mults_sent, dropped_sent);
    $display("checked %0d product elements, %0d of them clamped to a limit",
             products_checked, saturated_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
